[sv/owbm_pkg.sv]
// Package with shared types, codes and register defaults of the 1-Wire bus master.
`default_nettype none

package owbm_pkg;

    // Widths of the timing registers and the tick counter.
    localparam int unsigned CFG_W      = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned TICK_W     = CFG_W + 1;
    localparam int unsigned NUM_CFG    = 7;
    localparam int unsigned NUM_BUSES_DEF = 8;

    // Command codes carried on each beat.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW    = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RESET_TAIL   = 3'd2,
        CFG_SHORT_LOW    = 3'd3,
        CFG_WRITE0_LOW   = 3'd4,
        CFG_SAMPLE_DELAY = 3'd5,
        CFG_SLOT_TIME    = 3'd6,
        CFG_UNUSED       = 3'd7
    } t_cfg_idx;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_TAIL = 3'd3,
        PH_WRITE    = 3'd4,
        PH_READ     = 3'd5
    } t_phase;

    // Register values after reset.
    localparam logic [CFG_W-1:0] DEF_RESET_LOW     = 10'd480;
    localparam logic [CFG_W-1:0] DEF_PRESENCE_WAIT = 10'd70;
    localparam logic [CFG_W-1:0] DEF_RESET_TAIL    = 10'd410;
    localparam logic [CFG_W-1:0] DEF_SHORT_LOW     = 10'd6;
    localparam logic [CFG_W-1:0] DEF_WRITE0_LOW    = 10'd60;
    localparam logic [CFG_W-1:0] DEF_SAMPLE_DELAY  = 10'd9;
    localparam logic [CFG_W-1:0] DEF_SLOT_TIME     = 10'd70;

    // A timing register that holds zero acts as one.
    function automatic logic [CFG_W-1:0] eff_time(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

[sv/onewire_bus_master_core.sv]
// Top level of the 1-Wire bus master: tick sequencer with a registered result beat.
// The result beat for an input beat is registered and appears in the cycle after the beat is accepted.
// Throughput: one input beat per cycle; the single result register is refilled in the
// cycle it is taken, so the input side stalls only while a result waits unaccepted.
// Reset (synchronous, active low) returns the sequencer to idle, clears the sequencer state and the result
// valid flag and loads the timing registers with their defaults.
`default_nettype none

module onewire_bus_master_core #(
    parameter int unsigned NUM_BUSES = owbm_pkg::NUM_BUSES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Input beats.
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_op,
    input  wire logic [7:0]                   i_write_data,
    input  wire logic [2:0]                   i_bus_index,
    input  wire logic                         i_line_level,
    // Result beats.
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_drive_low,
    output logic [2:0]                        o_active_bus,
    output logic                              o_busy_res,
    output logic                              o_done_res,
    output logic                              o_presence,
    output logic [7:0]                        o_read_data,
    output logic                              o_ignored,
    // Configuration writes.
    input  wire logic                         i_cfg_we,
    input  wire logic [owbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [owbm_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import owbm_pkg::*;

    // Timing registers.
    logic [CFG_W-1:0] r_cfg [NUM_CFG];

    // Sequencer state.
    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [2:0]        r_bit, n_bit;
    logic [7:0]        r_shift, n_shift;
    logic [2:0]        r_sel, n_sel;
    logic              r_presence, n_presence;
    logic [7:0]        r_last_read, n_last_read;

    // Result register.
    logic r_out_valid;
    logic r_drive, n_drive;
    logic r_busy, n_busy;
    logic r_done, n_done;
    logic r_ign, n_ign;

    logic accept;

    // Bus index folded into range, worked out per index value at elaboration.
    logic [2:0] bus_mod [8];
    for (genvar k = 0; k < 8; k++) begin : g_bus_mod
        assign bus_mod[k] = 3'(k % NUM_BUSES);
    end

    // Effective timing values.
    logic [CFG_W-1:0] t_rst_low, t_pres_wait, t_rst_tail, t_short, t_wr0, t_samp_dly, t_slot;
    assign t_rst_low   = eff_time(r_cfg[CFG_RESET_LOW]);
    assign t_pres_wait = eff_time(r_cfg[CFG_PRESENCE_WAIT]);
    assign t_rst_tail  = eff_time(r_cfg[CFG_RESET_TAIL]);
    assign t_short     = eff_time(r_cfg[CFG_SHORT_LOW]);
    assign t_wr0       = eff_time(r_cfg[CFG_WRITE0_LOW]);
    assign t_samp_dly  = eff_time(r_cfg[CFG_SAMPLE_DELAY]);
    assign t_slot      = eff_time(r_cfg[CFG_SLOT_TIME]);

    // Input is taken whenever the result register is empty or being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Configuration register writes; an unused index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_RESET_LOW]     <= DEF_RESET_LOW;
            r_cfg[CFG_PRESENCE_WAIT] <= DEF_PRESENCE_WAIT;
            r_cfg[CFG_RESET_TAIL]    <= DEF_RESET_TAIL;
            r_cfg[CFG_SHORT_LOW]     <= DEF_SHORT_LOW;
            r_cfg[CFG_WRITE0_LOW]    <= DEF_WRITE0_LOW;
            r_cfg[CFG_SAMPLE_DELAY]  <= DEF_SAMPLE_DELAY;
            r_cfg[CFG_SLOT_TIME]     <= DEF_SLOT_TIME;
        end else if (i_cfg_we && (i_cfg_idx != CFG_UNUSED)) begin
            r_cfg[i_cfg_idx[CFG_IDX_W-1:0]] <= i_cfg_wdata;
        end
    end

    // Per-tick sequencer: command intake, then one step of the running phase.
    always_comb begin
        t_phase            ph;
        logic [TICK_W-1:0] tc;
        logic [TICK_W-1:0] tc_inc;
        logic [2:0]        bc;
        logic [7:0]        sb;
        logic              rd;
        logic [CFG_W-1:0]  low;
        logic [TICK_W-1:0] slot;
        logic [TICK_W-1:0] samp;
        logic              start;

        start = (t_op'(i_op) != OP_TICK) && (r_phase == PH_IDLE);
        n_ign = (t_op'(i_op) != OP_TICK) && (r_phase != PH_IDLE);

        ph          = r_phase;
        tc          = r_tick;
        bc          = r_bit;
        sb          = r_shift;
        n_sel       = r_sel;
        n_presence  = r_presence;
        n_last_read = r_last_read;
        n_drive     = 1'b0;
        n_done      = 1'b0;

        // A command accepted while idle runs its first tick right away.
        if (start) begin
            tc = '0;
            bc = '0;
            unique case (t_op'(i_op))
                OP_RESET: begin
                    n_sel = bus_mod[i_bus_index];
                    ph    = PH_RST_LOW;
                end
                OP_WRITE: begin
                    sb = i_write_data;
                    ph = PH_WRITE;
                end
                OP_READ: begin
                    sb = '0;
                    ph = PH_READ;
                end
                default: begin
                    ph = r_phase;
                end
            endcase
        end

        tc_inc = tc + TICK_W'(1);
        rd     = (ph == PH_READ);
        low    = (!rd && !sb[0]) ? t_wr0 : t_short;
        slot   = (TICK_W'(t_slot) < (TICK_W'(low) + TICK_W'(1))) ?
                 (TICK_W'(low) + TICK_W'(1)) : TICK_W'(t_slot);
        samp   = TICK_W'(t_short) + TICK_W'(t_samp_dly);
        if (samp > (slot - TICK_W'(1))) begin
            samp = slot - TICK_W'(1);
        end

        unique case (ph)
            PH_IDLE: begin
            end
            PH_RST_LOW: begin
                n_drive = 1'b1;
                tc      = tc_inc;
                if (tc >= TICK_W'(t_rst_low)) begin
                    ph = PH_RST_WAIT;
                    tc = '0;
                end
            end
            PH_RST_WAIT: begin
                if (tc < TICK_W'(t_pres_wait)) begin
                    tc = tc_inc;
                end else begin
                    // Sample tick: a low line means a device answered.
                    n_presence = !i_line_level;
                    tc         = TICK_W'(1);
                    if (t_rst_tail == CFG_W'(1)) begin
                        ph     = PH_IDLE;
                        tc     = '0;
                        n_done = 1'b1;
                    end else begin
                        ph = PH_RST_TAIL;
                    end
                end
            end
            PH_RST_TAIL: begin
                tc = tc_inc;
                if (tc >= TICK_W'(t_rst_tail)) begin
                    ph     = PH_IDLE;
                    tc     = '0;
                    n_done = 1'b1;
                end
            end
            PH_WRITE, PH_READ: begin
                n_drive = (tc < TICK_W'(low));
                if (rd && (tc == samp)) begin
                    sb = {i_line_level, sb[7:1]};
                end
                tc = tc_inc;
                if (tc >= slot) begin
                    tc = '0;
                    if (!rd) begin
                        sb = {1'b0, sb[7:1]};
                    end
                    if (bc == 3'd7) begin
                        if (rd) begin
                            n_last_read = sb;
                        end
                        bc     = '0;
                        ph     = PH_IDLE;
                        n_done = 1'b1;
                    end else begin
                        bc = bc + 3'd1;
                    end
                end
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase

        n_phase = ph;
        n_tick  = tc;
        n_bit   = bc;
        n_shift = sb;
        n_busy  = (ph != PH_IDLE);
    end

    // Sequencer state register, advanced once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_sel       <= '0;
            r_presence  <= 1'b0;
            r_last_read <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_sel       <= n_sel;
            r_presence  <= n_presence;
            r_last_read <= n_last_read;
        end
    end

    // Result beat valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result beat payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive <= n_drive;
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_ign   <= n_ign;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_drive_low  = r_drive;
    assign o_active_bus = r_sel;
    assign o_busy_res   = r_busy;
    assign o_done_res   = r_done;
    assign o_presence   = r_presence;
    assign o_read_data  = r_last_read;
    assign o_ignored    = r_ign;

endmodule

`default_nettype wire
